// ===== sv/bdl_pkg.sv =====
// Shared types and constants for the button debouncer with long-press detection.
package bdl_pkg;

  localparam int unsigned CfgWidth         = 16;
  localparam int unsigned TimerWidthDef    = 16;
  localparam logic [CfgWidth-1:0] DebounceRst  = 16'd10;
  localparam logic [CfgWidth-1:0] LongpressRst = 16'd500;

  typedef enum logic [0:0] {
    CFG_DEBOUNCE  = 1'b0,
    CFG_LONGPRESS = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic level;
    logic clear_press;
    logic clear_long;
  } in_t;

  typedef struct packed {
    logic stable_level;
    logic press_event;
    logic long_event;
  } out_t;

  // Control from the debounce core to one countdown timer.
  typedef struct packed {
    logic step;
    logic load;
    logic cancel;
  } tmr_ctl_t;

  // Status of one countdown timer after this tick's count-down step.
  typedef struct packed {
    logic active;
    logic expired;
  } tmr_sts_t;

endpackage

// ===== sv/bdl_timer.sv =====
// Countdown timer with saturating load, used for hold-off and long-press timing.
module bdl_timer
  import bdl_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TimerWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tmr_ctl_t            ctl_i,
  input  logic [CfgWidth-1:0] load_val_i,
  output tmr_sts_t            sts_o
);

  localparam logic [32:0] MaxW = (33'd1 << TIMER_WIDTH) - 33'd1;

  logic                   active_q, active_d;
  logic [TIMER_WIDTH-1:0] cnt_q, cnt_d;
  logic                   act_t;
  logic [TIMER_WIDTH-1:0] cnt_t;
  logic                   exp_t;
  logic [TIMER_WIDTH-1:0] load_sat;

  always_comb begin
    act_t = active_q;
    cnt_t = cnt_q;
    exp_t = 1'b0;
    if (active_q) begin
      if (cnt_q <= TIMER_WIDTH'(1)) begin
        act_t = 1'b0;
        cnt_t = '0;
        exp_t = 1'b1;
      end else begin
        cnt_t = cnt_q - TIMER_WIDTH'(1);
      end
    end
  end

  // A register value above the largest count saturates.
  assign load_sat = (33'(load_val_i) > MaxW) ? TIMER_WIDTH'(MaxW)
                                             : TIMER_WIDTH'(load_val_i);

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    if (ctl_i.step) begin
      active_d = act_t;
      cnt_d    = cnt_t;
      if (ctl_i.load) begin
        active_d = 1'b1;
        cnt_d    = load_sat;
      end else if (ctl_i.cancel) begin
        active_d = 1'b0;
        cnt_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  assign sts_o.active  = act_t;
  assign sts_o.expired = exp_t;

endmodule

// ===== sv/bdl_core.sv =====
// Debounce and press-flag state with its two timers, stepped once per tick.
module bdl_core
  import bdl_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TimerWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  in_t                 item_i,
  input  logic [CfgWidth-1:0] debounce_ticks_i,
  input  logic [CfgWidth-1:0] longpress_ticks_i,
  output out_t                res_o
);

  logic stable_q, stable_d;
  logic prev_q, prev_d;
  logic short_q, short_d;
  logic long_q, long_d;
  logic skip_q, skip_d;
  logic long_t, skip_t;
  logic changed;

  tmr_ctl_t ho_ctl, lp_ctl;
  tmr_sts_t ho_sts, lp_sts;

  bdl_timer #(.TIMER_WIDTH(TIMER_WIDTH)) u_holdoff (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ho_ctl),
    .load_val_i (debounce_ticks_i),
    .sts_o      (ho_sts)
  );

  bdl_timer #(.TIMER_WIDTH(TIMER_WIDTH)) u_longpress (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (lp_ctl),
    .load_val_i (longpress_ticks_i),
    .sts_o      (lp_sts)
  );

  assign changed = item_i.level != prev_q;

  always_comb begin
    long_t   = long_q | lp_sts.expired;
    skip_t   = skip_q | lp_sts.expired;
    stable_d = stable_q;
    short_d  = short_q;
    skip_d   = skip_t;
    ho_ctl   = '{step: step_i, load: 1'b0, cancel: 1'b0};
    lp_ctl   = '{step: step_i, load: 1'b0, cancel: 1'b0};
    if (changed) begin
      if (!ho_sts.active) begin
        stable_d = item_i.level;
        if (item_i.level) begin
          skip_d      = 1'b0;
          lp_ctl.load = 1'b1;
        end else begin
          // A release that ends a long press gives no short press.
          if (!skip_t) begin
            short_d = 1'b1;
          end
          lp_ctl.cancel = 1'b1;
        end
      end
      ho_ctl.load = 1'b1;
    end else if (!ho_sts.active) begin
      stable_d = item_i.level;
    end
    prev_d = item_i.level;

    res_o.stable_level = stable_d;
    res_o.press_event  = short_d | long_t;
    res_o.long_event   = long_t;

    long_d = long_t & ~item_i.clear_long;
    if (item_i.clear_press) begin
      short_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b0;
      prev_q   <= 1'b0;
      short_q  <= 1'b0;
      long_q   <= 1'b0;
      skip_q   <= 1'b0;
    end else if (step_i) begin
      stable_q <= stable_d;
      prev_q   <= prev_d;
      short_q  <= short_d;
      long_q   <= long_d;
      skip_q   <= skip_d;
    end
  end

endmodule

// ===== sv/button_debounce_longpress_unit.sv =====
// Top level of the button debouncer with long-press detection.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+---------------------------
//   tick in  | input     | in_valid_i / in_stall_o | in_data_i  (in_t)
//   result   | output    | out_valid_o/ out_stall_i| out_data_o (out_t)
//   config   | input     | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// A tick beat is registered on entry and processed once it can advance, where the
// state and both timers update and the result beat is registered, so a result beat
// is offered from the output register after its tick leaves the input register,
// and one beat is taken every cycle while the output is not stalled.
// The output register lets a new tick enter while a result still waits.
// Reset clears all state and loads the register defaults of 10 and 500 ticks.
module button_debounce_longpress_unit
  import bdl_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TimerWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,
  input  logic                cfg_we_i,
  input  cfg_reg_e            cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i
);

  logic [CfgWidth-1:0] debounce_q, longpress_q;
  logic in_vld_q;
  in_t  in_q;
  logic out_vld_q;
  out_t out_q;
  logic adv;
  out_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DebounceRst;
      longpress_q <= LongpressRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEBOUNCE:  debounce_q  <= cfg_wdata_i;
        CFG_LONGPRESS: longpress_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The staged tick moves on when the result register is free or being drained.
  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  bdl_core #(.TIMER_WIDTH(TIMER_WIDTH)) u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (adv),
    .item_i            (in_q),
    .debounce_ticks_i  (debounce_q),
    .longpress_ticks_i (longpress_q),
    .res_o             (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_long_implies_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.long_event || out_data_o.press_event))
    else $error("long_event reported without press_event");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q)
    else $error("input stalled while the input stage is empty");

  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("processed tick produced no result beat");

endmodule

// ===== bench/button_debounce_longpress_unit_tb.sv =====
// Self-checking testbench for the button debouncer with long-press detection.
`timescale 1ns / 100ps

module button_debounce_longpress_unit_tb;
  import bdl_pkg::*;

  localparam int CycleLimit = 200000;

  // Tracks the debounce state of one button and holds the reports it should give.
  class press_scoreboard;
    logic [CfgWidth-1:0] debounce_reg;
    logic [CfgWidth-1:0] longpress_reg;
    logic                stable;
    logic                last_level;
    logic                holdoff_on;
    logic [15:0]         holdoff_left;
    logic                long_on;
    logic [15:0]         long_left;
    logic                short_flag;
    logic                long_flag;
    logic                skip_release;
    out_t                pending_reports[$];
    int                  mismatches;
    int                  checked;
    int                  long_reports;
    int                  short_reports;

    function new();
      debounce_reg  = DebounceRst;
      longpress_reg = LongpressRst;
      stable        = 1'b0;
      last_level    = 1'b0;
      holdoff_on    = 1'b0;
      holdoff_left  = '0;
      long_on       = 1'b0;
      long_left     = '0;
      short_flag    = 1'b0;
      long_flag     = 1'b0;
      skip_release  = 1'b0;
      mismatches    = 0;
      checked       = 0;
      long_reports  = 0;
      short_reports = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CfgWidth-1:0] value);
      if (idx == CFG_DEBOUNCE) begin
        debounce_reg = value;
      end else begin
        longpress_reg = value;
      end
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction

    function void take_tick(in_t t);
      out_t rep;
      // Both timers count down before the level is looked at.
      if (holdoff_on) begin
        if (holdoff_left <= 16'd1) begin
          holdoff_left = '0;
          holdoff_on   = 1'b0;
        end else begin
          holdoff_left = holdoff_left - 16'd1;
        end
      end
      if (long_on) begin
        if (long_left <= 16'd1) begin
          long_left    = '0;
          long_on      = 1'b0;
          long_flag    = 1'b1;
          skip_release = 1'b1;
        end else begin
          long_left = long_left - 16'd1;
        end
      end
      if (t.level != last_level) begin
        if (!holdoff_on) begin
          stable = t.level;
          if (t.level) begin
            skip_release = 1'b0;
            long_on      = 1'b1;
            long_left    = longpress_reg;
          end else begin
            if (!skip_release) short_flag = 1'b1;
            long_on   = 1'b0;
            long_left = '0;
          end
        end
        holdoff_on   = 1'b1;
        holdoff_left = debounce_reg;
      end else if (!holdoff_on) begin
        stable = t.level;
      end
      last_level = t.level;
      rep.stable_level = stable;
      rep.press_event  = short_flag | long_flag;
      rep.long_event   = long_flag;
      pending_reports.push_back(rep);
      if (t.clear_press) short_flag = 1'b0;
      if (t.clear_long) long_flag = 1'b0;
    endfunction

    function void check_result(out_t got);
      out_t exp;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected report at %0t: stable=%b press=%b long=%b", $time,
                   got.stable_level, got.press_event, got.long_event);
        end
        return;
      end
      exp = pending_reports.pop_front();
      checked++;
      if (got.long_event === 1'b1) long_reports++;
      else if (got.press_event === 1'b1) short_reports++;
      if (got.stable_level !== exp.stable_level || got.press_event !== exp.press_event ||
          got.long_event !== exp.long_event) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch at %0t: expected stable=%b press=%b long=%b,", $time,
                   exp.stable_level, exp.press_event, exp.long_event);
          $display("  got stable=%b press=%b long=%b",
                   got.stable_level, got.press_event, got.long_event);
        end
      end
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_t                out_data_o;
  logic                cfg_we_i    = 1'b0;
  cfg_reg_e            cfg_idx_i   = CFG_DEBOUNCE;
  logic [CfgWidth-1:0] cfg_wdata_i = '0;

  press_scoreboard sb;
  int              cur_debounce;
  int              cur_longpress;
  int              burst_left = 0;
  int              ticks_sent = 0;
  int              settings_used = 0;
  int              cycle_count = 0;
  logic [8:0]      stall_phase = '0;

  button_debounce_longpress_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: check each accepted beat, then pick the next stall value.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    stall_phase <= stall_phase + 9'd1;
    case (stall_phase[8:7])
      2'd0: out_stall_i <= 1'b0;
      2'd1: out_stall_i <= ($urandom_range(0, 2) == 0);
      2'd2: out_stall_i <= (stall_phase[3:0] > 4'd10);
      default: out_stall_i <= ($urandom_range(0, 5) == 0);
    endcase
  end

  task automatic send_tick(input in_t t);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_tick(t);
    burst_left--;
    ticks_sent++;
  endtask

  task automatic send_level(input logic lvl);
    in_t t;
    t.level       = lvl;
    t.clear_press = ($urandom_range(0, 4) == 0);
    t.clear_long  = ($urandom_range(0, 4) == 0);
    send_tick(t);
  endtask

  task automatic run_level(input logic lvl, input int n);
    repeat (n) send_level(lvl);
  endtask

  task automatic wait_drained;
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgWidth-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic set_timing(input int db, input int lp);
    wait_drained();
    write_reg(CFG_DEBOUNCE, db[CfgWidth-1:0]);
    write_reg(CFG_LONGPRESS, lp[CfgWidth-1:0]);
    cur_debounce  = db;
    cur_longpress = lp;
    settings_used++;
  endtask

  // A bouncy press, a hold of short, boundary or long length, and a bouncy release.
  task automatic press_gesture;
    int hold;
    int settle;
    int bounces;
    bounces = $urandom_range(0, 3);
    for (int i = 0; i < bounces; i++) run_level(i % 2 == 0, 1);
    case ($urandom_range(0, 3))
      0: hold = $urandom_range(1, 12);
      1: hold = cur_longpress + $urandom_range(0, 2);
      2: hold = cur_longpress + $urandom_range(3, 15);
      default: hold = cur_debounce + $urandom_range(0, 2);
    endcase
    if (hold > 40) hold = $urandom_range(1, 40);
    if (hold < 1) hold = 1;
    run_level(1'b1, hold);
    bounces = $urandom_range(0, 3);
    for (int i = 0; i < bounces; i++) run_level(i % 2 == 1, 1);
    settle = cur_debounce + $urandom_range(1, 6);
    if (settle > 40) settle = $urandom_range(1, 40);
    run_level(1'b0, settle);
  endtask

  task automatic run_phase(input int db, input int lp, input int n);
    int target;
    set_timing(db, lp);
    target = ticks_sent + n;
    while (ticks_sent < target) begin
      if ($urandom_range(0, 4) != 0) begin
        press_gesture();
      end else begin
        repeat ($urandom_range(1, 8)) send_level(1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    logic [2:0] at_reset[3]  = '{3'b100, 3'b100, 3'b000};
    // Zero timer settings: a press turns long on the very next tick.
    logic [2:0] at_zero[11]  = '{3'b100, 3'b100, 3'b110, 3'b101, 3'b000, 3'b000,
                                 3'b100, 3'b000, 3'b011, 3'b111, 3'b000};
    logic [2:0] at_short[11] = '{3'b100, 3'b100, 3'b000, 3'b010, 3'b000, 3'b100,
                                 3'b100, 3'b100, 3'b100, 3'b000, 3'b001};
    sb = new();
    cur_debounce  = DebounceRst;
    cur_longpress = LongpressRst;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (at_reset[i]) send_tick(in_t'(at_reset[i]));
    set_timing(0, 0);
    foreach (at_zero[i]) send_tick(in_t'(at_zero[i]));
    set_timing(1, 3);
    foreach (at_short[i]) send_tick(in_t'(at_short[i]));

    run_phase(1, 1, 80);
    run_phase(2, 5, 110);
    run_phase(3, 12, 120);
    run_phase(0, 7, 80);
    run_phase(4, 30, 120);
    run_phase(65535, 1, 40);
    run_phase(1, 65535, 50);
    run_phase(65535, 65535, 30);
    run_phase(7, 20, 90);

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d ticks under %0d timing settings, from zero to full-scale timers.",
             ticks_sent, settings_used);
    $display("Checked %0d reports: %0d long press, %0d short press only, %0d mismatches.",
             sb.checked, sb.long_reports, sb.short_reports, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== button_debounce_longpress_unit.f =====
sv/bdl_pkg.sv
sv/bdl_timer.sv
sv/bdl_core.sv
sv/button_debounce_longpress_unit.sv
bench/button_debounce_longpress_unit_tb.sv
